[hdl/rfsock_pkg.sv]
// ----------------------------------------------------------------------------
// rfsock_pkg
// Types and constants shared by the remote socket code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rfsock_pkg;

    localparam int unsigned FRAME_LEN   = 49;
    localparam int unsigned COUNT_SAT   = 50;
    localparam int unsigned SYNC_DIV    = 31;
    localparam int unsigned CODE_W      = 24;
    localparam int unsigned PULSE_W     = 16;
    localparam int unsigned SYNC_W      = 12;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W  = 16;

    localparam logic [15:0] THRESH_RST  = 16'd700;
    localparam logic [11:0] SYNC_LO_RST = 12'd290;
    localparam logic [11:0] SYNC_HI_RST = 12'd400;

    localparam logic [19:0] MOTION_PREFIX  = 20'b00000100000000000001;
    localparam logic [3:0]  POWER_ON_CODE  = 4'b0001;
    localparam logic [3:0]  POWER_OFF_CODE = 4'b0100;

    localparam logic [9:0] BTN_A = 10'b0001010101;
    localparam logic [9:0] BTN_B = 10'b0100010101;
    localparam logic [9:0] BTN_C = 10'b0101000101;
    localparam logic [9:0] BTN_D = 10'b0101010001;
    localparam logic [9:0] BTN_E = 10'b0101010100;

    typedef enum logic [1:0] {
        CFG_THRESH  = 2'd0,
        CFG_SYNC_LO = 2'd1,
        CFG_SYNC_HI = 2'd2
    } t_cfg_addr;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_SYNC = 2'd1,
        FAULT_PAIR = 2'd2
    } t_fault;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEN   = 3'd1,
        ST_BAD_SYNC  = 3'd2,
        ST_BAD_PAIR  = 3'd3,
        ST_BAD_GROUP = 3'd4,
        ST_BAD_BTN   = 3'd5,
        ST_BAD_POWER = 3'd6
    } t_status;

    typedef struct packed {
        logic [PULSE_W-1:0] thresh;
        logic [SYNC_W-1:0]  sync_lo;
        logic [SYNC_W-1:0]  sync_hi;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [CODE_W-1:0]  code;
        logic               first_long;
        t_fault             fault;
    } t_frame;

    typedef struct packed {
        t_status    status;
        logic [4:0] group_bits;
        logic [2:0] button;
        logic       power_on;
        logic       motion_pattern;
        logic       motion_on;
    } t_result;

endpackage

`default_nettype wire

[hdl/rfsock_frame.sv]
// ----------------------------------------------------------------------------
// rfsock_frame
// Frame state: pulse count, sync check, pair decode into the code shift.
// ----------------------------------------------------------------------------
`default_nettype none

module rfsock_frame (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_take,
    input  wire logic [rfsock_pkg::PULSE_W-1:0] i_pulse_us,
    input  wire logic                           i_last,
    input  wire rfsock_pkg::t_cfg               i_cfg,
    output rfsock_pkg::t_frame                  o_view
);

    rfsock_pkg::t_frame r_frame;
    rfsock_pkg::t_frame n_frame;

    logic [17:0] sync_min;
    logic [17:0] sync_max;
    logic [12:0] lo_p1;
    logic        sync_ok;
    logic        second_long;
    logic        pair_bit;
    logic        pair_ok;

    always_comb begin
        lo_p1    = {1'b0, i_cfg.sync_lo} + 13'd1;
        sync_min = ({5'd0, lo_p1} << 5) - {5'd0, lo_p1};
        sync_max = ({6'd0, i_cfg.sync_hi} << 5) - {6'd0, i_cfg.sync_hi};
        sync_ok  = ({2'b0, i_pulse_us} >= sync_min) && ({2'b0, i_pulse_us} < sync_max);

        second_long = i_pulse_us >= i_cfg.thresh;
        pair_bit    = r_frame.first_long && !second_long;
        pair_ok     = pair_bit || (!r_frame.first_long && second_long);

        n_frame = r_frame;
        if (r_frame.count == '0) begin
            if (!sync_ok && r_frame.fault == rfsock_pkg::FAULT_NONE) begin
                n_frame.fault = rfsock_pkg::FAULT_SYNC;
            end
        end else if (r_frame.count < rfsock_pkg::COUNT_W'(rfsock_pkg::FRAME_LEN)) begin
            if (r_frame.count[0]) begin
                n_frame.first_long = i_pulse_us > i_cfg.thresh;
            end else begin
                if (!pair_ok && r_frame.fault == rfsock_pkg::FAULT_NONE) begin
                    n_frame.fault = rfsock_pkg::FAULT_PAIR;
                end
                n_frame.code = {r_frame.code[rfsock_pkg::CODE_W-2:0], pair_bit};
            end
        end
        if (r_frame.count < rfsock_pkg::COUNT_W'(rfsock_pkg::COUNT_SAT)) begin
            n_frame.count = r_frame.count + 1'b1;
        end
    end

    assign o_view = n_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_frame <= '0;
            end else begin
                r_frame <= n_frame;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/rfsock_decode.sv]
// ----------------------------------------------------------------------------
// rfsock_decode
// Frame check and code word decode into group, button, power and motion.
// ----------------------------------------------------------------------------
`default_nettype none

module rfsock_decode (
    input  wire rfsock_pkg::t_frame i_frame,
    output rfsock_pkg::t_result     o_result
);

    logic [23:0] code;
    logic [3:0]  last4;
    logic [9:0]  btn_code;
    logic [4:0]  group;
    logic        group_bad;
    logic [2:0]  button;
    logic        btn_found;
    logic        mpat;

    always_comb begin
        code      = i_frame.code;
        last4     = code[3:0];
        btn_code  = code[13:4];
        group_bad = 1'b0;
        for (int k = 0; k < 5; k++) begin
            group[k]  = code[23-2*k -: 2] == 2'b00;
            group_bad = group_bad | code[23-2*k];
        end

        btn_found = 1'b1;
        button    = 3'd0;
        unique case (btn_code)
            rfsock_pkg::BTN_A: button = 3'd0;
            rfsock_pkg::BTN_B: button = 3'd1;
            rfsock_pkg::BTN_C: button = 3'd2;
            rfsock_pkg::BTN_D: button = 3'd3;
            rfsock_pkg::BTN_E: button = 3'd4;
            default:           btn_found = 1'b0;
        endcase

        mpat = code[23:4] == rfsock_pkg::MOTION_PREFIX;

        o_result = '0;
        if (i_frame.count != rfsock_pkg::COUNT_W'(rfsock_pkg::FRAME_LEN)) begin
            o_result.status = rfsock_pkg::ST_BAD_LEN;
        end else if (i_frame.fault == rfsock_pkg::FAULT_SYNC) begin
            o_result.status = rfsock_pkg::ST_BAD_SYNC;
        end else if (i_frame.fault != rfsock_pkg::FAULT_NONE) begin
            o_result.status = rfsock_pkg::ST_BAD_PAIR;
        end else begin
            o_result.motion_pattern = mpat;
            o_result.motion_on      = mpat && (last4 != rfsock_pkg::POWER_OFF_CODE);
            if (group_bad) begin
                o_result.status = rfsock_pkg::ST_BAD_GROUP;
            end else if (!btn_found) begin
                o_result.status = rfsock_pkg::ST_BAD_BTN;
            end else if (last4 != rfsock_pkg::POWER_ON_CODE &&
                         last4 != rfsock_pkg::POWER_OFF_CODE) begin
                o_result.status = rfsock_pkg::ST_BAD_POWER;
            end else begin
                o_result.status     = rfsock_pkg::ST_OK;
                o_result.group_bits = group;
                o_result.button     = button;
                o_result.power_on   = last4 == rfsock_pkg::POWER_ON_CODE;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/rf433_socket_code_decoder.sv]
// ----------------------------------------------------------------------------
// rf433_socket_code_decoder
// Decodes sync plus 24 short/long pulse pairs of a remote socket frame.
//
//   channel   dir  handshake             payload
//   s_axis    in   tvalid/tready         tdata: pulse_us; tlast: last_of_frame
//   m_axis    out  tvalid/tready         tdata: one result per frame
//   cfg       in   valid/ready           addr: register index; data: value
//
// One pulse per cycle sustained: an input register, then one pass of compare
// logic into the frame state and the result register. A frame result is
// registered as its last pulse leaves the input register. A held result
// stalls only the last pulse of the next frame. Reset clears frame state and
// restores the configuration defaults; cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rf433_socket_code_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [15:0]                       i_s_axis_tdata,  // [15:0] pulse_us
    input  wire logic                              i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [2:0] status, [7:3] group_bits, [10:8] button, [11] power_on,
    // [12] motion_pattern, [13] motion_on, [15:14] zero
    output logic [rfsock_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rfsock_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [rfsock_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rfsock_pkg::t_cfg    r_cfg;
    logic                r_in_vld;
    logic [15:0]         r_in_pulse;
    logic                r_in_last;
    logic                r_out_vld;
    rfsock_pkg::t_result r_out;

    rfsock_pkg::t_frame  frame_view;
    rfsock_pkg::t_result result;
    logic                out_free;
    logic                in_move;

    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign in_move         = r_in_vld && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_vld || in_move;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresh  <= rfsock_pkg::THRESH_RST;
            r_cfg.sync_lo <= rfsock_pkg::SYNC_LO_RST;
            r_cfg.sync_hi <= rfsock_pkg::SYNC_HI_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                rfsock_pkg::CFG_THRESH:  r_cfg.thresh  <= i_cfg_data;
                rfsock_pkg::CFG_SYNC_LO: r_cfg.sync_lo <= i_cfg_data[11:0];
                rfsock_pkg::CFG_SYNC_HI: r_cfg.sync_hi <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_pulse <= i_s_axis_tdata;
            r_in_last  <= i_s_axis_tlast;
        end
    end

    rfsock_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (in_move),
        .i_pulse_us (r_in_pulse),
        .i_last     (r_in_last),
        .i_cfg      (r_cfg),
        .o_view     (frame_view)
    );

    rfsock_decode u_decode (
        .i_frame  (frame_view),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (in_move && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_move && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_out.motion_on, r_out.motion_pattern, r_out.power_on,
                              r_out.button, r_out.group_bits, r_out.status};

endmodule

`default_nettype wire

[hdl/rfsock_checker.sv]
// ----------------------------------------------------------------------------
// rfsock_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rfsock_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [15:0] o_m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[2:0] != 3'd7 && o_m_axis_tdata[15:14] == 2'b00)
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2:0] != 3'd0 |-> o_m_axis_tdata[11:3] == 9'd0)
        else $error("decoded fields set on failed frame");

    a_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[13] |-> o_m_axis_tdata[12])
        else $error("motion state without motion prefix");

endmodule

bind rf433_socket_code_decoder rfsock_checker u_rfsock_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

[test/tb_rf433_socket_code_decoder.sv]
// ----------------------------------------------------------------------------
// tb_rf433_socket_code_decoder
// Sends remote socket frames as pulse durations and checks every frame result
// against a predictor of the decoder. Directed frames under the reset defaults
// come first. Random frames follow under several threshold and sync-window
// settings, the extremes among them. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rf433_socket_code_decoder;

    localparam int LIMIT        = 500000;
    localparam int PHASES       = 9;
    localparam int PHASE_PULSES = 130;

    localparam logic [4:0][9:0] BUTTONS = {rfsock_pkg::BTN_E, rfsock_pkg::BTN_D,
                                           rfsock_pkg::BTN_C, rfsock_pkg::BTN_B,
                                           rfsock_pkg::BTN_A};

    typedef enum {FL_NONE, FL_SYNC, FL_PAIR, FL_NOISE} t_flaw;

    class socket_code_ledger;
        logic [15:0]         thresh;
        logic [11:0]         sync_lo;
        logic [11:0]         sync_hi;
        logic [5:0]          count;
        logic [23:0]         code;
        logic                first_long;
        rfsock_pkg::t_fault  fault;
        rfsock_pkg::t_result decoded_frames[$];
        int                  errors;

        function new();
            thresh  = rfsock_pkg::THRESH_RST;
            sync_lo = rfsock_pkg::SYNC_LO_RST;
            sync_hi = rfsock_pkg::SYNC_HI_RST;
            errors  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            count      = '0;
            code       = '0;
            first_long = 1'b0;
            fault      = rfsock_pkg::FAULT_NONE;
        endfunction

        function void set_reg(rfsock_pkg::t_cfg_addr addr, logic [15:0] value);
            case (addr)
                rfsock_pkg::CFG_THRESH:  thresh  = value;
                rfsock_pkg::CFG_SYNC_LO: sync_lo = value[11:0];
                rfsock_pkg::CFG_SYNC_HI: sync_hi = value[11:0];
                default: ;
            endcase
        endfunction

        function rfsock_pkg::t_result close_frame();
            rfsock_pkg::t_result r;
            logic [3:0] last4;
            logic [1:0] pair;
            r = '0;
            last4 = code[3:0];
            if (count != rfsock_pkg::FRAME_LEN) begin
                r.status = rfsock_pkg::ST_BAD_LEN;
            end else if (fault == rfsock_pkg::FAULT_SYNC) begin
                r.status = rfsock_pkg::ST_BAD_SYNC;
            end else if (fault != rfsock_pkg::FAULT_NONE) begin
                r.status = rfsock_pkg::ST_BAD_PAIR;
            end else begin
                r.motion_pattern = (code[23:4] == rfsock_pkg::MOTION_PREFIX);
                r.motion_on = r.motion_pattern && (last4 != rfsock_pkg::POWER_OFF_CODE);
                for (int k = 0; k < 5; k++) begin
                    pair = code[22-2*k +: 2];
                    if (r.status == rfsock_pkg::ST_OK) begin
                        if (pair == 2'b00)
                            r.group_bits[k] = 1'b1;
                        else if (pair != 2'b01)
                            r.status = rfsock_pkg::ST_BAD_GROUP;
                    end
                end
                if (r.status == rfsock_pkg::ST_OK) begin
                    case (code[13:4])
                        rfsock_pkg::BTN_A: r.button = 3'd0;
                        rfsock_pkg::BTN_B: r.button = 3'd1;
                        rfsock_pkg::BTN_C: r.button = 3'd2;
                        rfsock_pkg::BTN_D: r.button = 3'd3;
                        rfsock_pkg::BTN_E: r.button = 3'd4;
                        default: r.status = rfsock_pkg::ST_BAD_BTN;
                    endcase
                end
                if (r.status == rfsock_pkg::ST_OK) begin
                    if (last4 == rfsock_pkg::POWER_ON_CODE)
                        r.power_on = 1'b1;
                    else if (last4 != rfsock_pkg::POWER_OFF_CODE)
                        r.status = rfsock_pkg::ST_BAD_POWER;
                end
                if (r.status != rfsock_pkg::ST_OK) begin
                    r.group_bits = '0;
                    r.button     = '0;
                    r.power_on   = 1'b0;
                end
            end
            return r;
        endfunction

        function void take_pulse(logic [15:0] us, logic last);
            int unsigned quot;
            logic second_long;
            logic bit_v;
            if (count == 0) begin
                quot = us / rfsock_pkg::SYNC_DIV;
                if (!(quot > sync_lo && quot < sync_hi) && fault == rfsock_pkg::FAULT_NONE)
                    fault = rfsock_pkg::FAULT_SYNC;
            end else if (count < rfsock_pkg::FRAME_LEN) begin
                if (count[0]) begin
                    first_long = (us > thresh);
                end else begin
                    second_long = (us >= thresh);
                    bit_v = first_long && !second_long;
                    if (!bit_v && !(!first_long && second_long) &&
                        fault == rfsock_pkg::FAULT_NONE)
                        fault = rfsock_pkg::FAULT_PAIR;
                    code = {code[22:0], bit_v};
                end
            end
            if (count < rfsock_pkg::COUNT_SAT)
                count++;
            if (last) begin
                decoded_frames.push_back(close_frame());
                clear_frame();
            end
        endfunction

        function void check_result(logic [15:0] data);
            rfsock_pkg::t_result got;
            rfsock_pkg::t_result want;
            got.status         = rfsock_pkg::t_status'(data[2:0]);
            got.group_bits     = data[7:3];
            got.button         = data[10:8];
            got.power_on       = data[11];
            got.motion_pattern = data[12];
            got.motion_on      = data[13];
            if (decoded_frames.size() == 0) begin
                if (errors < 10)
                    $display("result %h with no frame pending", data);
                errors++;
            end else begin
                want = decoded_frames.pop_front();
                if (got != want || data[15:14] != 2'b00) begin
                    if (errors < 10)
                        $display({"mismatch: expected st=%0d grp=%b btn=%0d pwr=%b mot=%b/%b",
                                  " got st=%0d grp=%b btn=%0d pwr=%b mot=%b/%b pad=%b"},
                                 want.status, want.group_bits, want.button, want.power_on,
                                 want.motion_pattern, want.motion_on,
                                 got.status, got.group_bits, got.button, got.power_on,
                                 got.motion_pattern, got.motion_on, data[15:14]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_data = '0;

    logic        rush = 1'b0;
    int          cycles = 0;
    int          pulses_sent = 0;

    socket_code_ledger codes = new();

    rf433_socket_code_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int pick_in(input int lo, input int hi);
        int sel;
        sel = $urandom_range(3, 0);
        if (sel == 0)
            return lo;
        if (sel == 1)
            return hi;
        return $urandom_range(hi, lo);
    endfunction

    function automatic logic [15:0] first_pulse(input logic is_long);
        int t;
        t = codes.thresh;
        if (is_long)
            return (t == 65535) ? 16'hFFFF : 16'(pick_in(t + 1, 65535));
        return 16'(pick_in(0, t));
    endfunction

    function automatic logic [15:0] second_pulse(input logic is_long);
        int t;
        t = codes.thresh;
        if (is_long)
            return 16'(pick_in(t, 65535));
        return (t == 0) ? 16'h0000 : 16'(pick_in(0, t - 1));
    endfunction

    function automatic logic [15:0] sync_pulse(input logic good);
        int lo_us;
        int hi_us;
        int lo_top;
        lo_us = (int'(codes.sync_lo) + 1) * 31;
        hi_us = int'(codes.sync_hi) * 31 - 1;
        if (hi_us > 65535)
            hi_us = 65535;
        lo_top = (lo_us - 1 > 65535) ? 65535 : lo_us - 1;
        if (good) begin
            if (lo_us <= hi_us)
                return 16'(pick_in(lo_us, hi_us));
            return 16'($urandom_range(65535, 0));
        end
        if (hi_us >= 65535 || $urandom_range(1, 0))
            return 16'(pick_in(0, lo_top));
        return 16'(pick_in(hi_us + 1, 65535));
    endfunction

    function automatic logic [23:0] make_code(input logic [4:0] on_mask,
                                              input logic [9:0] btn,
                                              input logic [3:0] pwr);
        logic [23:0] c;
        for (int k = 0; k < 5; k++)
            c[22-2*k +: 2] = on_mask[k] ? 2'b00 : 2'b01;
        c[13:4] = btn;
        c[3:0]  = pwr;
        return c;
    endfunction

    function automatic logic [23:0] random_code();
        logic [23:0] c;
        int kind;
        int k;
        kind = $urandom_range(9, 0);
        c = make_code(5'($urandom_range(31, 0)), BUTTONS[$urandom_range(4, 0)],
                      $urandom_range(1, 0) ? rfsock_pkg::POWER_ON_CODE
                                           : rfsock_pkg::POWER_OFF_CODE);
        case (kind)
            5: c = {rfsock_pkg::MOTION_PREFIX,
                    $urandom_range(1, 0) ? rfsock_pkg::POWER_OFF_CODE
                                         : 4'($urandom_range(15, 0))};
            6: begin
                k = $urandom_range(4, 0);
                c[22-2*k +: 2] = {1'b1, 1'($urandom_range(1, 0))};
            end
            7: c[13:4] = 10'($urandom_range(1023, 0));
            8: c[3:0] = 4'($urandom_range(15, 0));
            9: c = 24'($urandom);
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_pulse(input logic [15:0] us, input logic last);
        int gap;
        gap = rush ? 0 : $urandom_range(14, 0);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= us;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        codes.take_pulse(us, last);
        pulses_sent++;
    endtask

    task automatic send_frame(input logic [23:0] code, input int len, input t_flaw flaw);
        int bad_pair;
        int p;
        logic b;
        logic long_mode;
        logic [15:0] us;
        bad_pair  = $urandom_range(23, 0);
        long_mode = $urandom_range(1, 0);
        rush = ($urandom_range(4, 0) == 0);
        for (int i = 0; i < len; i++) begin
            if (flaw == FL_NOISE || i >= rfsock_pkg::FRAME_LEN) begin
                us = 16'($urandom_range(65535, 0));
            end else if (i == 0) begin
                us = sync_pulse(flaw != FL_SYNC);
            end else begin
                p = (i - 1) / 2;
                b = code[23-p];
                if (flaw == FL_PAIR && p == bad_pair)
                    us = (i % 2) ? first_pulse(long_mode) : second_pulse(long_mode);
                else
                    us = (i % 2) ? first_pulse(b) : second_pulse(b);
            end
            send_pulse(us, i == len - 1);
        end
    endtask

    task automatic hold_and_drain();
        i_s_axis_tvalid <= 1'b0;
        while (codes.decoded_frames.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input rfsock_pkg::t_cfg_addr addr, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        codes.set_reg(addr, value);
    endtask

    task automatic set_config(input logic [15:0] th, input logic [15:0] lo,
                              input logic [15:0] hi);
        write_reg(rfsock_pkg::CFG_THRESH, th);
        write_reg(rfsock_pkg::CFG_SYNC_LO, lo);
        write_reg(rfsock_pkg::CFG_SYNC_HI, hi);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_frame();
        int sel;
        int len;
        t_flaw flaw;
        sel  = $urandom_range(99, 0);
        len  = rfsock_pkg::FRAME_LEN;
        flaw = FL_NONE;
        if (sel < 8)
            flaw = FL_SYNC;
        else if (sel < 16)
            flaw = FL_PAIR;
        else if (sel < 20)
            flaw = FL_NOISE;
        else if (sel < 26)
            len = $urandom_range(1, 0) ? $urandom_range(48, 1) : $urandom_range(60, 50);
        send_frame(random_code(), len, flaw);
    endtask

    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = rush ? 0 : $urandom_range(14, 0);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            codes.check_result(o_m_axis_tdata);
        end
    end

    initial begin
        logic [23:0] c;
        int lo;
        int phase_start;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(make_code(5'b00000, rfsock_pkg::BTN_A, rfsock_pkg::POWER_ON_CODE),
                   rfsock_pkg::FRAME_LEN, FL_NONE);
        send_frame(make_code(5'b11111, rfsock_pkg::BTN_B, rfsock_pkg::POWER_OFF_CODE),
                   rfsock_pkg::FRAME_LEN, FL_NONE);
        send_frame(make_code(5'b10101, rfsock_pkg::BTN_C, rfsock_pkg::POWER_ON_CODE),
                   rfsock_pkg::FRAME_LEN, FL_NONE);
        send_frame(make_code(5'b01010, rfsock_pkg::BTN_D, rfsock_pkg::POWER_OFF_CODE),
                   rfsock_pkg::FRAME_LEN, FL_NONE);
        send_frame(make_code(5'b10011, rfsock_pkg::BTN_E, rfsock_pkg::POWER_ON_CODE),
                   rfsock_pkg::FRAME_LEN, FL_NONE);
        send_frame({rfsock_pkg::MOTION_PREFIX, rfsock_pkg::POWER_OFF_CODE},
                   rfsock_pkg::FRAME_LEN, FL_NONE);
        send_frame({rfsock_pkg::MOTION_PREFIX, rfsock_pkg::POWER_ON_CODE},
                   rfsock_pkg::FRAME_LEN, FL_NONE);
        c = make_code(5'b00000, rfsock_pkg::BTN_A, rfsock_pkg::POWER_ON_CODE);
        c[23:22] = 2'b11;
        send_frame(c, rfsock_pkg::FRAME_LEN, FL_NONE);
        send_frame(make_code(5'b11111, 10'h3FF, rfsock_pkg::POWER_ON_CODE),
                   rfsock_pkg::FRAME_LEN, FL_NONE);
        send_frame(make_code(5'b00001, rfsock_pkg::BTN_C, 4'hF),
                   rfsock_pkg::FRAME_LEN, FL_NONE);
        send_frame(make_code(5'b00100, rfsock_pkg::BTN_B, rfsock_pkg::POWER_ON_CODE),
                   rfsock_pkg::FRAME_LEN, FL_SYNC);
        send_frame(make_code(5'b01000, rfsock_pkg::BTN_D, rfsock_pkg::POWER_ON_CODE),
                   rfsock_pkg::FRAME_LEN, FL_PAIR);
        send_frame(make_code(5'b11000, rfsock_pkg::BTN_E, rfsock_pkg::POWER_OFF_CODE),
                   55, FL_NONE);
        send_frame(make_code(5'b00011, rfsock_pkg::BTN_A, rfsock_pkg::POWER_OFF_CODE),
                   30, FL_NONE);
        send_pulse(16'h0000, 1'b1);
        send_pulse(16'hFFFF, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            hold_and_drain();
            case (ph)
                0: set_config(rfsock_pkg::THRESH_RST, 16'(rfsock_pkg::SYNC_LO_RST),
                              16'(rfsock_pkg::SYNC_HI_RST));
                1: set_config(16'd0, 16'd0, 16'd4095);
                2: set_config(16'hFFFF, 16'd4095, 16'd0);
                3: set_config(16'd1, 16'd0, 16'd2);
                4: set_config(16'hFFFE, 16'd2113, 16'd2115);
                6: set_config(16'd300, 16'd500, 16'd500);
                default: begin
                    lo = $urandom_range(800, 0);
                    set_config(16'($urandom_range(3000, 50)),
                               {4'($urandom_range(15, 0)), 12'(lo)},
                               {4'($urandom_range(15, 0)), 12'(lo + $urandom_range(400, 2))});
                end
            endcase
            phase_start = pulses_sent;
            while (pulses_sent - phase_start < PHASE_PULSES) begin
                if ($urandom_range(9, 0) == 0)
                    hold_and_drain();
                random_frame();
            end
        end

        hold_and_drain();
        if (codes.errors == 0 && codes.decoded_frames.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
hdl/rfsock_pkg.sv
hdl/rfsock_frame.sv
hdl/rfsock_decode.sv
hdl/rf433_socket_code_decoder.sv
hdl/rfsock_checker.sv
test/tb_rf433_socket_code_decoder.sv
